### sv/swept_box_collision_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the swept box collision checker.
// ---------------------------------------------------------------------------
`ifndef SWEPT_BOX_COLLISION_TOP_MACROS_SVH
`define SWEPT_BOX_COLLISION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while reset is held.
`define SBC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swept box collision: property failed");

// Next-cycle implication, sampled on clk, quiet while reset is held.
`define SBC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swept box collision: property failed");

`endif

### sv/sbc_pkg.sv
// ---------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the swept box collision block.
// ---------------------------------------------------------------------------
package sbc_pkg;

    // Default number of fraction bits of the time result.
    localparam int TIME_FRAC_BITS_DEF = 15;

    // Signed distance width and unsigned displacement magnitude width.
    localparam int DIST_W = 18;
    localparam int VEL_W  = 16;

    // Queue depths: between front and back, and in front of the result ports.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 32;

    // Two-bit signed normal codes.
    localparam logic [1:0] NORM_NONE = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

    // One distance ready for division.
    typedef struct packed {
        logic [DIST_W-1:0] mag;
        logic              sat;
        logic              neg;
    } sbc_lane_t;

    // A classified item as handed from the front to the back.
    typedef struct packed {
        sbc_lane_t         x_in;
        sbc_lane_t         x_out;
        sbc_lane_t         y_in;
        sbc_lane_t         y_out;
        logic [VEL_W-1:0]  vx_mag;
        logic [VEL_W-1:0]  vy_mag;
        logic              vx_zero;
        logic              vy_zero;
        logic              dx_in_neg;
        logic              dy_in_neg;
    } sbc_job_t;

    // Flags that travel beside the dividers.
    typedef struct packed {
        logic [3:0] sat;
        logic [3:0] neg;
        logic       vx_zero;
        logic       vy_zero;
        logic       dx_in_neg;
        logic       dy_in_neg;
    } sbc_side_t;

    // One result item.
    typedef struct packed {
        logic [15:0] hit_time;
        logic        hit;
        logic [1:0]  normal_x;
        logic [1:0]  normal_y;
    } sbc_res_t;

endpackage

### sv/sbc_queue.sv
// ---------------------------------------------------------------------------
// sbc_queue
// Small first-in first-out queue of register entries with a count.
// ---------------------------------------------------------------------------
module sbc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  store_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_reg;
    logic [PW-1:0] rd_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_reg];

    // Pointer and count updates for each transfer.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_reg] <= din;
        end
    end

endmodule

### sv/sbc_front.sv
// ---------------------------------------------------------------------------
// sbc_front
// Forms entry and exit distances per axis, takes magnitudes and flags the
// quotients that are out of range, then queues the classified item.
// ---------------------------------------------------------------------------
module sbc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  mover_x,
    input  logic signed [15:0]  mover_y,
    input  logic [14:0]         mover_w,
    input  logic [14:0]         mover_h,
    input  logic signed [15:0]  mover_vx,
    input  logic signed [15:0]  mover_vy,
    input  logic signed [15:0]  target_x,
    input  logic signed [15:0]  target_y,
    input  logic [14:0]         target_w,
    input  logic [14:0]         target_h,
    output sbc_pkg::sbc_job_t   job,
    output logic                job_empty,
    input  logic                job_take
);

    localparam int DW = sbc_pkg::DIST_W;
    localparam int VW = sbc_pkg::VEL_W;

    logic signed [DW-1:0] x_near;
    logic signed [DW-1:0] x_far;
    logic signed [DW-1:0] y_near;
    logic signed [DW-1:0] y_far;
    logic signed [DW-1:0] dx_in;
    logic signed [DW-1:0] dx_out;
    logic signed [DW-1:0] dy_in;
    logic signed [DW-1:0] dy_out;
    logic [VW-1:0]        vx_mag;
    logic [VW-1:0]        vy_mag;
    logic                 vx_pos;
    logic                 vy_pos;
    sbc_pkg::sbc_job_t    job_in;

    // Gap to the near face and reach to the far face on each axis.
    always_comb
    begin
        x_near = DW'(target_x) - DW'(mover_x) - $signed({3'b000, mover_w});
        x_far  = DW'(target_x) + $signed({3'b000, target_w}) - DW'(mover_x);
        y_near = DW'(target_y) - DW'(mover_y) - $signed({3'b000, mover_h});
        y_far  = DW'(target_y) + $signed({3'b000, target_h}) - DW'(mover_y);
        vx_pos = !mover_vx[15] && (mover_vx != '0);
        vy_pos = !mover_vy[15] && (mover_vy != '0);
        dx_in  = vx_pos ? x_near : x_far;
        dx_out = vx_pos ? x_far  : x_near;
        dy_in  = vy_pos ? y_near : y_far;
        dy_out = vy_pos ? y_far  : y_near;
        vx_mag = mover_vx[15] ? VW'(-mover_vx) : VW'(mover_vx);
        vy_mag = mover_vy[15] ? VW'(-mover_vy) : VW'(mover_vy);
    end

    // Magnitude, sign and saturation flag of one distance over one speed.
    function automatic sbc_pkg::sbc_lane_t classify(
        input logic signed [DW-1:0] gap,
        input logic [VW-1:0]        vmag,
        input logic                 vneg
    );
        sbc_pkg::sbc_lane_t lane;
        lane.mag = gap[DW-1] ? DW'(-gap) : DW'(gap);
        lane.sat = {1'b0, lane.mag} >= {{(DW - VW){1'b0}}, vmag, 1'b0};
        lane.neg = gap[DW-1] ^ vneg;
        return lane;
    endfunction

    always_comb
    begin
        job_in.x_in      = classify(dx_in,  vx_mag, mover_vx[15]);
        job_in.x_out     = classify(dx_out, vx_mag, mover_vx[15]);
        job_in.y_in      = classify(dy_in,  vy_mag, mover_vy[15]);
        job_in.y_out     = classify(dy_out, vy_mag, mover_vy[15]);
        job_in.vx_mag    = vx_mag;
        job_in.vy_mag    = vy_mag;
        job_in.vx_zero   = (mover_vx == '0);
        job_in.vy_zero   = (mover_vy == '0);
        job_in.dx_in_neg = dx_in[DW-1];
        job_in.dy_in_neg = dy_in[DW-1];
    end

    // Queue that decouples the front from the back.
    sbc_queue #(
        .W     ($bits(sbc_pkg::sbc_job_t)),
        .DEPTH (sbc_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_in),
        .full  (full),
        .pop   (job_take),
        .dout  (job),
        .empty (job_empty)
    );

endmodule

### sv/sbc_div.sv
// ---------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider producing one quotient bit per stage. The
// dividend is known to be below twice the divisor, so the quotient has
// TIME_FRAC_BITS + 1 bits.
// ---------------------------------------------------------------------------
module sbc_div #(
    parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic [sbc_pkg::DIST_W-1:0]    nd,
    input  logic [sbc_pkg::VEL_W-1:0]     nv,
    output logic [TIME_FRAC_BITS:0]       q
);

    localparam int NS = TIME_FRAC_BITS + 1;
    localparam int DW = sbc_pkg::DIST_W;
    localparam int VW = sbc_pkg::VEL_W;
    localparam int RW = VW + 1;

    logic [RW-1:0] rem_reg [NS];
    logic [NS-1:0] quo_reg [NS];
    logic [VW-1:0] nv_reg  [NS];

    // First stage: the integer bit of the quotient.
    logic          ge0;
    logic [DW-1:0] diff0;

    always_comb
    begin
        ge0   = nd >= {{(DW - VW){1'b0}}, nv};
        diff0 = nd - {{(DW - VW){1'b0}}, nv};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= ge0 ? diff0[RW-1:0] : nd[RW-1:0];
        quo_reg[0] <= {ge0, {(NS - 1){1'b0}}};
        nv_reg[0]  <= nv;
    end

    // Remaining stages: one fraction bit each.
    for (genvar s = 1; s < NS; s++)
    begin : g_stage
        logic [RW-1:0] twice;
        logic          ge;

        always_comb
        begin
            twice = {rem_reg[s-1][RW-2:0], 1'b0};
            ge    = twice >= {1'b0, nv_reg[s-1]};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= ge ? twice - {1'b0, nv_reg[s-1]} : twice;
            quo_reg[s] <= quo_reg[s-1] | (NS'(ge) << (NS - 1 - s));
            nv_reg[s]  <= nv_reg[s-1];
        end
    end

    assign q = quo_reg[NS-1];

endmodule

### sv/sbc_back.sv
// ---------------------------------------------------------------------------
// sbc_back
// Takes classified items, divides the four distances in parallel pipelines,
// clips the times, decides hit and normal and queues the result.
// ---------------------------------------------------------------------------
module sbc_back #(
    parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sbc_pkg::sbc_job_t   job,
    input  logic                job_empty,
    output logic                job_take,
    input  logic                pop,
    output logic                empty,
    output sbc_pkg::sbc_res_t   res
);

    localparam int NS  = TIME_FRAC_BITS + 1;
    localparam int TW  = TIME_FRAC_BITS + 2;
    localparam int CW  = $clog2(sbc_pkg::OUT_DEPTH + 1);
    localparam logic signed [TW-1:0] ONE_T  = TW'(1) << TIME_FRAC_BITS;
    localparam logic signed [TW-1:0] OVER_T = ONE_T + TW'(1);
    localparam logic signed [TW-1:0] NEG_T  = -TW'(1);

    logic [CW-1:0]       credit_reg;
    logic [CW-1:0]       credit_next;
    logic                out_full;
    logic                res_pop;
    logic [NS-1:0]       q_xi;
    logic [NS-1:0]       q_xo;
    logic [NS-1:0]       q_yi;
    logic [NS-1:0]       q_yo;
    logic                vld_reg [NS];
    sbc_pkg::sbc_side_t  side_reg [NS];
    sbc_pkg::sbc_side_t  side_in;
    sbc_pkg::sbc_side_t  side_last;
    logic                clip_vld_reg;
    logic signed [TW-1:0] xe_reg;
    logic signed [TW-1:0] xx_reg;
    logic signed [TW-1:0] ye_reg;
    logic signed [TW-1:0] yx_reg;
    logic                dxn_reg;
    logic                dyn_reg;
    sbc_pkg::sbc_res_t   res_in;

    // Issue only when the result queue is sure to have room for the item.
    assign job_take = !job_empty && !out_full && (credit_reg < CW'(sbc_pkg::OUT_DEPTH));
    assign res_pop  = pop && !empty;

    always_comb
    begin
        credit_next = credit_reg;
        if (job_take && !res_pop)
        begin
            credit_next = credit_reg + CW'(1);
        end
        else if (res_pop && !job_take)
        begin
            credit_next = credit_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // Four dividers, one for each entry and exit time.
    sbc_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_xi
        (.clk(clk), .nd(job.x_in.mag),  .nv(job.vx_mag), .q(q_xi));
    sbc_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_xo
        (.clk(clk), .nd(job.x_out.mag), .nv(job.vx_mag), .q(q_xo));
    sbc_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_yi
        (.clk(clk), .nd(job.y_in.mag),  .nv(job.vy_mag), .q(q_yi));
    sbc_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_yo
        (.clk(clk), .nd(job.y_out.mag), .nv(job.vy_mag), .q(q_yo));

    // Flags travel in step with the dividers.
    always_comb
    begin
        side_in.sat       = {job.x_in.sat, job.x_out.sat, job.y_in.sat, job.y_out.sat};
        side_in.neg       = {job.x_in.neg, job.x_out.neg, job.y_in.neg, job.y_out.neg};
        side_in.vx_zero   = job.vx_zero;
        side_in.vy_zero   = job.vy_zero;
        side_in.dx_in_neg = job.dx_in_neg;
        side_in.dy_in_neg = job.dy_in_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= job_take;
            for (int i = 1; i < NS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int i = 1; i < NS; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_last = side_reg[NS-1];

    // Clip a quotient to the range that can still change the outcome.
    function automatic logic signed [TW-1:0] clip(
        input logic [NS-1:0] qv,
        input logic          sat,
        input logic          neg,
        input logic          zero,
        input logic          entry
    );
        logic signed [TW-1:0] t;
        if (zero)
        begin
            t = entry ? NEG_T : OVER_T;
        end
        else if (sat || ($signed({1'b0, qv}) > ONE_T))
        begin
            t = neg ? NEG_T : OVER_T;
        end
        else if (neg && (qv != '0))
        begin
            t = NEG_T;
        end
        else
        begin
            t = $signed({1'b0, qv});
        end
        return t;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_vld_reg <= 1'b0;
        end
        else
        begin
            clip_vld_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        xe_reg  <= clip(q_xi, side_last.sat[3], side_last.neg[3], side_last.vx_zero, 1'b1);
        xx_reg  <= clip(q_xo, side_last.sat[2], side_last.neg[2], side_last.vx_zero, 1'b0);
        ye_reg  <= clip(q_yi, side_last.sat[1], side_last.neg[1], side_last.vy_zero, 1'b1);
        yx_reg  <= clip(q_yo, side_last.sat[0], side_last.neg[0], side_last.vy_zero, 1'b0);
        dxn_reg <= side_last.dx_in_neg;
        dyn_reg <= side_last.dy_in_neg;
    end

    // Hit decision and face choice.
    logic signed [TW-1:0] t_in;
    logic signed [TW-1:0] t_out;
    logic                 hit_now;
    logic [TW+15:0]       t_ext;
    logic [TW+15:0]       one_ext;

    always_comb
    begin
        t_in    = (xe_reg > ye_reg) ? xe_reg : ye_reg;
        t_out   = (xx_reg < yx_reg) ? xx_reg : yx_reg;
        hit_now = !((t_in > t_out) || (xe_reg[TW-1] && ye_reg[TW-1]) ||
                    (xe_reg > ONE_T) || (ye_reg > ONE_T));
        t_ext   = {16'h0000, t_in};
        one_ext = {16'h0000, ONE_T};
        res_in.hit      = hit_now;
        res_in.hit_time = hit_now ? t_ext[15:0] : one_ext[15:0];
        res_in.normal_x = sbc_pkg::NORM_NONE;
        res_in.normal_y = sbc_pkg::NORM_NONE;
        if (hit_now)
        begin
            if (xe_reg > ye_reg)
            begin
                res_in.normal_x = dxn_reg ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
            end
            else
            begin
                res_in.normal_y = dyn_reg ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
            end
        end
    end

    // Result queue; credits keep it from overflowing.
    sbc_queue #(
        .W     ($bits(sbc_pkg::sbc_res_t)),
        .DEPTH (sbc_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (clip_vld_reg),
        .din   (res_in),
        .full  (out_full),
        .pop   (pop),
        .dout  (res),
        .empty (empty)
    );

endmodule

### sv/swept_box_collision_top.sv
// ---------------------------------------------------------------------------
// swept_box_collision_top
// Swept box collision: entry time and struck face of a moving box against a
// still box within one step.
// ---------------------------------------------------------------------------
//   Channel   Handshake        Transfer when      Payload
//   input     push / full      push && !full      mover_*, target_*
//   result    empty / pop      pop && !empty      hit_time, hit, normal_x/y
//
// One item is taken per cycle while full is low, one result leaves per cycle
// while empty is low. An input passes the front queue, the divider stages and
// the clip register into the result queue. Reset clears all queues and valid
// bits; no clearing pass is needed. A stalled result side fills the result
// queue, then the front queue, and then raises full.
// ---------------------------------------------------------------------------
module swept_box_collision_top #(
    parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] mover_x,
    input  logic signed [15:0] mover_y,
    input  logic [14:0]        mover_w,
    input  logic [14:0]        mover_h,
    input  logic signed [15:0] mover_vx,
    input  logic signed [15:0] mover_vy,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic [14:0]        target_w,
    input  logic [14:0]        target_h,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        hit_time,
    output logic               hit,
    output logic signed [1:0]  normal_x,
    output logic signed [1:0]  normal_y
);

    sbc_pkg::sbc_job_t job;
    logic              job_empty;
    logic              job_take;
    sbc_pkg::sbc_res_t res;

    // Front: distances and classification.
    sbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mover_x   (mover_x),
        .mover_y   (mover_y),
        .mover_w   (mover_w),
        .mover_h   (mover_h),
        .mover_vx  (mover_vx),
        .mover_vy  (mover_vy),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_w  (target_w),
        .target_h  (target_h),
        .job       (job),
        .job_empty (job_empty),
        .job_take  (job_take)
    );

    // Back: division, decision and result queue.
    sbc_back #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_empty (job_empty),
        .job_take  (job_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign hit_time = res.hit_time;
    assign hit      = res.hit;
    assign normal_x = res.normal_x;
    assign normal_y = res.normal_y;

endmodule

### sv/sbc_checker.sv
// ---------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the result side of the swept box collision block.
// ---------------------------------------------------------------------------
`include "swept_box_collision_top_macros.svh"

module sbc_checker #(
    parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              pop,
    input logic              empty,
    input logic [15:0]       hit_time,
    input logic              hit,
    input logic signed [1:0] normal_x,
    input logic signed [1:0] normal_y
);

    localparam logic [TIME_FRAC_BITS+16:0] ONE_EXT = (TIME_FRAC_BITS + 17)'(1) << TIME_FRAC_BITS;
    localparam logic [15:0] ONE16 = ONE_EXT[15:0];

    // A miss reports time one and no face.
    `SBC_ASSERT_IMP(a_miss_time, !empty && !hit, hit_time == ONE16)
    `SBC_ASSERT_IMP(a_miss_norm, !empty && !hit, normal_x == 2'b00 && normal_y == 2'b00)
    // A hit names exactly one face.
    `SBC_ASSERT_IMP(a_hit_face, !empty && hit, (normal_x != 2'b00) != (normal_y != 2'b00))
    // A waiting result is not withdrawn.
    `SBC_ASSERT_NXT(a_res_holds, !empty && !pop, !empty)

endmodule

bind swept_box_collision_top sbc_checker #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
) u_sbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .empty    (empty),
    .hit_time (hit_time),
    .hit      (hit),
    .normal_x (normal_x),
    .normal_y (normal_y)
);

### bench/swept_box_collision_checker.sv
// ---------------------------------------------------------------------------
// Swept box collision checker
// Watches the input and result channels of the swept box collision block,
// predicts the entry time, hit flag and struck face of every input transfer,
// and compares each result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module swept_box_collision_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [15:0] mover_x,
    input  logic signed [15:0] mover_y,
    input  logic [14:0]        mover_w,
    input  logic [14:0]        mover_h,
    input  logic signed [15:0] mover_vx,
    input  logic signed [15:0] mover_vy,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic [14:0]        target_w,
    input  logic [14:0]        target_h,
    input  logic               empty,
    input  logic               pop,
    input  logic [15:0]        hit_time,
    input  logic               hit,
    input  logic signed [1:0]  normal_x,
    input  logic signed [1:0]  normal_y,
    output int                 failures,
    output int                 pending
);

    localparam longint INF_T = longint'(1) << 50;
    localparam longint ONE_T = longint'(1) << sbc_pkg::TIME_FRAC_BITS_DEF;

    sbc_pkg::sbc_res_t collision_q[$];

    // Time of travel over a distance, truncated toward zero.
    function automatic longint travel_time(longint gap, longint vel);
        longint nd;
        longint nv;
        longint q;
        nd = gap < 0 ? -gap : gap;
        nv = vel < 0 ? -vel : vel;
        q = (nd << sbc_pkg::TIME_FRAC_BITS_DEF) / nv;
        return ((gap < 0) != (vel < 0)) ? -q : q;
    endfunction

    // Predicts the result of one sweep of the mover against the target.
    function automatic sbc_pkg::sbc_res_t sweep_box(
        longint mx, longint my, longint mw, longint mh, longint vx, longint vy,
        longint tx, longint ty, longint tw, longint th);
        sbc_pkg::sbc_res_t r;
        longint dx_in, dx_out, dy_in, dy_out;
        longint xe, xx, ye, yx, t_in, t_out;
        bit     touch;
        if (vx > 0)
        begin
            dx_in = tx - (mx + mw);
            dx_out = (tx + tw) - mx;
        end
        else
        begin
            dx_in = (tx + tw) - mx;
            dx_out = tx - (mx + mw);
        end
        if (vy > 0)
        begin
            dy_in = ty - (my + mh);
            dy_out = (ty + th) - my;
        end
        else
        begin
            dy_in = (ty + th) - my;
            dy_out = ty - (my + mh);
        end
        xe = (vx == 0) ? -INF_T : travel_time(dx_in, vx);
        xx = (vx == 0) ? INF_T : travel_time(dx_out, vx);
        ye = (vy == 0) ? -INF_T : travel_time(dy_in, vy);
        yx = (vy == 0) ? INF_T : travel_time(dy_out, vy);
        t_in = xe > ye ? xe : ye;
        t_out = xx < yx ? xx : yx;
        touch = !(t_in > t_out || (xe < 0 && ye < 0) || xe > ONE_T || ye > ONE_T);
        r.normal_x = sbc_pkg::NORM_NONE;
        r.normal_y = sbc_pkg::NORM_NONE;
        if (touch)
        begin
            if (xe > ye)
                r.normal_x = dx_in < 0 ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
            else
                r.normal_y = dy_in < 0 ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
            r.hit_time = t_in[15:0];
            r.hit = 1'b1;
        end
        else
        begin
            r.hit_time = ONE_T[15:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    assign pending = collision_q.size();

    // Prediction on input transfers and comparison on result transfers.
    always @(posedge clk or negedge rst_n)
    begin
        sbc_pkg::sbc_res_t want;
        int                bad;
        bad = 0;
        if (!rst_n)
        begin
            failures <= 0;
            collision_q.delete();
        end
        else
        begin
            if (push && !full)
                collision_q.push_back(sweep_box(mover_x, mover_y, mover_w, mover_h,
                    mover_vx, mover_vy, target_x, target_y, target_w, target_h));
            if (pop && !empty)
            begin
                if (collision_q.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    bad = bad + 1;
                end
                else
                begin
                    want = collision_q.pop_front();
                    if (hit_time !== want.hit_time)
                    begin
                        $error("hit_time: expected %0d, got %0d", want.hit_time, hit_time);
                        bad = bad + 1;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        bad = bad + 1;
                    end
                    if (normal_x !== want.normal_x)
                    begin
                        $error("normal_x: expected %0d, got %0d", want.normal_x, normal_x);
                        bad = bad + 1;
                    end
                    if (normal_y !== want.normal_y)
                    begin
                        $error("normal_y: expected %0d, got %0d", want.normal_y, normal_y);
                        bad = bad + 1;
                    end
                end
            end
            failures <= failures + bad;
        end
    end
endmodule

### bench/tb_swept_box_collision_top.sv
// ---------------------------------------------------------------------------
// Swept box collision regression
// Drives directed and random box pairs into the block with random gaps on
// both channels, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module tb_swept_box_collision_top;

    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = sbc_pkg::TIME_FRAC_BITS_DEF + 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] mover_x = '0;
    logic signed [15:0] mover_y = '0;
    logic [14:0]        mover_w = '0;
    logic [14:0]        mover_h = '0;
    logic signed [15:0] mover_vx = '0;
    logic signed [15:0] mover_vy = '0;
    logic signed [15:0] target_x = '0;
    logic signed [15:0] target_y = '0;
    logic [14:0]        target_w = '0;
    logic [14:0]        target_h = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [15:0]        hit_time;
    logic               hit;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
    int                 failures;
    int                 pending;
    bit                 steady = 1'b0;

    always #4 clk = ~clk;

    swept_box_collision_top i_dut (.*);

    swept_box_collision_checker i_checker (.*);

    // The result side stalls at random, except during the steady stretch.
    always @(posedge clk)
        pop <= steady || ($urandom_range(99) >= 7);

    // Offers one box pair and holds it until the transfer takes place.
    task automatic send_pair(
        logic [15:0] mx, logic [15:0] my, logic [14:0] mw, logic [14:0] mh,
        logic [15:0] vx, logic [15:0] vy, logic [15:0] tx, logic [15:0] ty,
        logic [14:0] tw, logic [14:0] th);
        while (!steady && $urandom_range(99) < 7)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        mover_x <= mx;
        mover_y <= my;
        mover_w <= mw;
        mover_h <= mh;
        mover_vx <= vx;
        mover_vy <= vy;
        target_x <= tx;
        target_y <= ty;
        target_w <= tw;
        target_h <= th;
        do
            @(posedge clk);
        while (full);
    endtask

    // A pair set up to meet within the step, with small random jitter.
    task automatic send_near_pair();
        int          dx;
        int          dy;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] mx;
        logic [15:0] my;
        dx = $urandom_range(1200) - 600;
        dy = $urandom_range(1200) - 600;
        mx = 16'($urandom);
        my = 16'($urandom);
        vx = $urandom_range(3) == 0 ? 16'd0 : 16'(-dx + int'($urandom_range(200)) - 100);
        vy = $urandom_range(3) == 0 ? 16'd0 : 16'(-dy + int'($urandom_range(200)) - 100);
        send_pair(mx, my, 15'($urandom_range(300)),
            15'($urandom_range(300)), vx, vy, 16'(int'(mx) - dx), 16'(int'(my) - dy),
            15'($urandom_range(300)), 15'($urandom_range(300)));
    endtask

    // Stimulus: directed corners, then mostly near pairs with some noise.
    initial
    begin
        int          n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Head-on along x, hitting the left face.
        send_pair(16'd0, 16'd0, 15'd16, 15'd16, 16'd64, 16'd0, 16'd32, 16'd0, 15'd16, 15'd16);
        // Along y from above, hitting the top face.
        send_pair(16'd0, 16'd64, 15'd16, 15'd16, 16'd0, -16'sd64, 16'd0, 16'd0, 15'd16, 15'd16);
        // Both displacements zero: never a hit.
        send_pair(16'd0, 16'd0, 15'd16, 15'd16, 16'd0, 16'd0, 16'd0, 16'd0, 15'd16, 15'd16);
        // Still axis without overlap still lets the x hit through.
        send_pair(16'd0, 16'd0, 15'd16, 15'd16, 16'd64, 16'd0, 16'd32, 16'd500, 15'd16, 15'd16);
        // Equal entry times on both axes: the face comes from y.
        send_pair(16'd0, 16'd0, 15'd16, 15'd16, 16'd32, 16'd32, 16'd32, 16'd32, 15'd16, 15'd16);
        // Touching at exactly the end of the step.
        send_pair(16'd0, 16'd0, 15'd16, 15'd16, 16'd16, 16'd0, 16'd32, 16'd0, 15'd16, 15'd16);
        // Entering from the right moving left.
        send_pair(16'd100, 16'd0, 15'd16, 15'd16, -16'sd100, 16'd0, 16'd0, 16'd0, 15'd16, 15'd16);
        // Field extremes: largest sizes and displacements, most negative corners.
        send_pair(16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 16'h7fff, 16'h7fff,
            16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
        send_pair(16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 16'h8000, 16'h8000,
            16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
        send_pair(16'h8000, 16'h7fff, 15'd0, 15'h7fff, 16'hffff, 16'd1,
            16'h7fff, 16'h8000, 15'h7fff, 15'd0);
        send_pair(16'hffff, 16'hffff, 15'h7fff, 15'd0, 16'd1, 16'hffff,
            16'd0, 16'd0, 15'd0, 15'h7fff);
        // Moving away: no hit.
        send_pair(16'd0, 16'd0, 15'd16, 15'd16, -16'sd64, -16'sd64, 16'd100, 16'd100, 15'd16, 15'd16);

        // Random part, with one steady stretch free of gaps.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 200 && n < 260);
            if ($urandom_range(3) != 0)
                send_near_pair();
            else
                send_pair(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    15'($urandom), 15'($urandom));
            // The sender holds off once until every prediction has been met.
            if (n == 300)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
        steady = 1'b0;
        push <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("swept_box_collision_top regression: pass");
        else
            $display("swept_box_collision_top regression: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("swept_box_collision_top regression: fail");
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/sbc_pkg.sv
sv/sbc_queue.sv
sv/sbc_front.sv
sv/sbc_div.sv
sv/sbc_back.sv
sv/swept_box_collision_top.sv
sv/sbc_checker.sv
bench/swept_box_collision_checker.sv
bench/tb_swept_box_collision_top.sv
